/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the Microwire read master checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MWE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("mwe assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MWE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("mwe assertion failed");

`endif

/* rtl/core/mwe_pkg.sv */
// ----------------------------------------------------------------------------
// mwe_pkg
// Types and constants shared by the Microwire EEPROM read master.
// ----------------------------------------------------------------------------
`default_nettype none

package mwe_pkg;

  localparam int unsigned AW_W      = 4;   // addr_width register width
  localparam int unsigned LOC_W     = 8;   // word address field width
  localparam int unsigned CMD_W     = 13;  // latched command word width
  localparam int unsigned CNT_W     = 5;   // bit counter width
  localparam int unsigned VALUE_W   = 29;  // shifted-in result width
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 2;

  localparam logic [CNT_W-1:0] DATA_BITS = CNT_W'(16);
  localparam logic [CNT_W-1:0] CMD_EXTRA = CNT_W'(4);
  localparam logic [2:0]       READ_OPCODE = 3'b110;
  localparam logic [AW_W-1:0]  AW_MIN   = AW_W'(6);
  localparam logic [AW_W-1:0]  AW_MAX   = AW_W'(8);
  localparam logic [AW_W-1:0]  AW_RESET = AW_W'(6);

  // Sequencer phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_SEL_HIGH  = 8'b0000_0010,
    PH_CMD_LOW   = 8'b0000_0100,
    PH_CMD_HIGH  = 8'b0000_1000,
    PH_GAP       = 8'b0001_0000,
    PH_DATA_HIGH = 8'b0010_0000,
    PH_DATA_LOW  = 8'b0100_0000,
    PH_DESELECT  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic             action;
    logic [LOC_W-1:0] location;
    logic             data_in;
  } in_item_t;

  typedef struct packed {
    logic               chip_select;
    logic               shift_clock;
    logic               data_out;
    logic               busy_res;
    logic               done_res;
    logic [VALUE_W-1:0] read_value;
  } out_item_t;

  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   bit_count;
    logic [CMD_W-1:0]   command_bits;
    logic [VALUE_W-1:0] shift_in;
  } seq_state_t;

endpackage

`default_nettype wire

/* rtl/core/microwire_eeprom_read_master_core.sv */
// A tick's pin levels appear on out_data in the cycle after the tick is accepted.
// Throughput: one tick per clock cycle while the output slot is free or being drained; the sequencer state
// and the output register both update in the cycle a tick is accepted.
// A read spans 2*(clamped addr_width+5) + 36 ticks, start tick and done tick included.
// Reset (rst_n low, synchronous): sequencer idle, counters and shift-in register cleared,
// addr_width back to 6, no result pending.
// ----------------------------------------------------------------------------
// microwire_eeprom_read_master_core
// Tick-driven Microwire serial EEPROM read master with APB configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module microwire_eeprom_read_master_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // tick input
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire mwe_pkg::in_item_t          in_data,
  // pin result output
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output mwe_pkg::out_item_t              out_data,
  // configuration
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [mwe_pkg::APB_AW-1:0] cfg_paddr,
  input  wire logic [mwe_pkg::APB_DW-1:0] cfg_pwdata,
  output logic      [mwe_pkg::APB_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import mwe_pkg::*;

  logic [AW_W-1:0] addr_width;
  seq_state_t      state_r;
  seq_state_t      state_nxt;
  out_item_t       result;
  out_item_t       out_data_r;
  logic            out_valid_r;
  logic            accept;

  mwe_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .addr_width (addr_width)
  );

  mwe_step u_step (
    .addr_width (addr_width),
    .state      (state_r),
    .item       (in_data),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  // Take a new tick whenever the output slot is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Advance sequencer state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= PH_IDLE;
      state_r.bit_count    <= '0;
      state_r.command_bits <= '0;
      state_r.shift_in     <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/core/mwe_cfg.sv */
// ----------------------------------------------------------------------------
// mwe_cfg
// APB register slice holding the addr_width setting, with readback.
// ----------------------------------------------------------------------------
`default_nettype none

module mwe_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mwe_pkg::APB_AW-1:0]    paddr,
  input  wire logic [mwe_pkg::APB_DW-1:0]    pwdata,
  output logic      [mwe_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  output logic      [mwe_pkg::AW_W-1:0]      addr_width
);
  import mwe_pkg::*;

  logic [AW_W-1:0] addr_width_r;
  logic            wr_en;

  // Single register; every address in the slot decodes to it
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == '0 || paddr != '0);

  // Hold the setting until software writes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_width_r <= AW_RESET;
    end else if (wr_en) begin
      addr_width_r <= pwdata[AW_W-1:0];
    end
  end

  assign prdata     = {{(APB_DW-AW_W){1'b0}}, addr_width_r};
  assign addr_width = addr_width_r;

endmodule

`default_nettype wire

/* rtl/core/mwe_step.sv */
// ----------------------------------------------------------------------------
// mwe_step
// Next-state and pin logic for one tick of the Microwire read sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module mwe_step (
  input  wire logic                    [mwe_pkg::AW_W-1:0] addr_width,
  input  wire mwe_pkg::seq_state_t     state,
  input  wire mwe_pkg::in_item_t       item,
  output mwe_pkg::seq_state_t          state_nxt,
  output mwe_pkg::out_item_t           result
);
  import mwe_pkg::*;

  logic [AW_W-1:0]    aw;
  logic [LOC_W-1:0]   loc_mask;
  logic [CMD_W-1:0]   cmd_word;
  logic [CMD_W-1:0]   cmd_shift;
  logic [VALUE_W-1:0] sampled;
  logic               busy;
  logic               done;

  // Clamp the width into the supported range
  always_comb begin
    if (addr_width < AW_MIN) begin
      aw = AW_MIN;
    end else if (addr_width > AW_MAX) begin
      aw = AW_MAX;
    end else begin
      aw = addr_width;
    end
  end

  // Build the read command: opcode over the masked address
  assign loc_mask  = LOC_W'((9'd1 << aw) - 9'd1);
  assign cmd_word  = (CMD_W'(READ_OPCODE) << aw) | CMD_W'(item.location & loc_mask);
  assign cmd_shift = state.command_bits >> state.bit_count[3:0];
  assign sampled   = {state.shift_in[VALUE_W-2:0], item.data_in};

  // Advance the sequencer one tick
  always_comb begin
    state_nxt          = state;
    result.chip_select = 1'b0;
    result.shift_clock = 1'b0;
    result.data_out    = 1'b0;
    busy               = 1'b1;
    done               = 1'b0;
    case (state.phase)
      PH_IDLE: begin
        busy = 1'b0;
        if (item.action) begin
          state_nxt.command_bits = cmd_word;
          state_nxt.bit_count    = CMD_EXTRA + CNT_W'(aw);
          state_nxt.shift_in     = '0;
          state_nxt.phase        = PH_SEL_HIGH;
          busy                   = 1'b1;
        end
      end
      PH_SEL_HIGH: begin
        result.chip_select = 1'b1;
        state_nxt.phase    = PH_CMD_LOW;
      end
      PH_CMD_LOW: begin
        result.chip_select = 1'b1;
        result.data_out    = cmd_shift[0];
        state_nxt.phase    = PH_CMD_HIGH;
      end
      PH_CMD_HIGH: begin
        result.chip_select = 1'b1;
        result.shift_clock = 1'b1;
        result.data_out    = cmd_shift[0];
        state_nxt.shift_in = sampled;
        if (state.bit_count == '0) begin
          state_nxt.phase = PH_GAP;
        end else begin
          state_nxt.bit_count = state.bit_count - CNT_W'(1);
          state_nxt.phase     = PH_CMD_LOW;
        end
      end
      PH_GAP: begin
        result.chip_select  = 1'b1;
        state_nxt.bit_count = DATA_BITS - CNT_W'(1);
        state_nxt.phase     = PH_DATA_HIGH;
      end
      PH_DATA_HIGH: begin
        result.chip_select = 1'b1;
        result.shift_clock = 1'b1;
        state_nxt.shift_in = sampled;
        state_nxt.phase    = PH_DATA_LOW;
      end
      PH_DATA_LOW: begin
        result.chip_select = 1'b1;
        if (state.bit_count == '0) begin
          state_nxt.phase = PH_DESELECT;
        end else begin
          state_nxt.bit_count = state.bit_count - CNT_W'(1);
          state_nxt.phase     = PH_DATA_HIGH;
        end
      end
      default: begin
        done                = 1'b1;
        state_nxt.bit_count = '0;
        state_nxt.phase     = PH_IDLE;
      end
    endcase
    result.busy_res   = busy;
    result.done_res   = done;
    result.read_value = state_nxt.shift_in;
  end

endmodule

`default_nettype wire

/* rtl/core/mwe_checker.sv */
// ----------------------------------------------------------------------------
// mwe_checker
// Port-level checks for the Microwire read master, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mwe_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire mwe_pkg::out_item_t out_data
);
  import mwe_pkg::*;

  logic done_tick;
  logic clk_tick;
  logic dout_tick;

  // Qualify each pin event with a valid result
  assign done_tick = out_valid && out_data.done_res;
  assign clk_tick  = out_valid && out_data.shift_clock;
  assign dout_tick = out_valid && out_data.data_out;

  // Stalled result holds
  `MWE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // Done tick deselects the part while still reporting busy
  `MWE_ASSERT_IMP(a_done_desel, clk, rst_n, done_tick, out_data.busy_res && !out_data.chip_select)
  // Shift clock only pulses while selected and busy
  `MWE_ASSERT_IMP(a_clk_sel, clk, rst_n, clk_tick, out_data.chip_select && out_data.busy_res)
  // Data-out driven only while selected
  `MWE_ASSERT_IMP(a_dout_sel, clk, rst_n, dout_tick, out_data.chip_select && !out_data.done_res)

endmodule

bind microwire_eeprom_read_master_core mwe_checker u_mwe_checker (.*);

`default_nettype wire
